/* design/avt_pkg.sv */
// Shared types and constants for the affine vertex transform block.
// No dependencies; imported by every module of the block.
package avt_pkg;

    localparam int DATA_W        = 32;
    localparam int VEC_W         = DATA_W + 1;
    localparam int LANES         = 4;
    localparam int MAT_N         = LANES * LANES;
    localparam int DEF_FRAC_BITS = 16;

    typedef enum logic [2:0] {
        CMD_LOAD      = 3'd0,
        CMD_INVERT    = 3'd1,
        CMD_POINT     = 3'd2,
        CMD_DIRECTION = 3'd3,
        CMD_HOMOG     = 3'd4
    } cmd_t;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [VEC_W-1:0]  vword_t;

    // Stage load enables that the core hands to every lane
    typedef struct packed {
        logic load_op;
        logic load_prod;
        logic load_sum;
    } lane_ctrl_t;

    // Last pipeline stage as seen by the merge stage
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } merge_ctrl_t;

endpackage

/* design/avt_lane.sv */
// One dot-product lane: four truncated products, summed and saturated.
// Depends on avt_pkg.
module avt_lane
    import avt_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic       clk,
    input  lane_ctrl_t ctrl,
    input  word_t      coef [LANES],
    input  vword_t     vec [LANES],
    output word_t      res,
    output logic       ovf
);

    localparam int FULL_W = DATA_W + VEC_W;
    localparam int PROD_W = FULL_W - FRAC_BITS;
    localparam int SUM_W  = PROD_W + 2;

    word_t                     coef_reg [LANES];
    logic signed [FULL_W-1:0]  full [LANES];
    logic signed [PROD_W-1:0]  prod_reg [LANES];
    logic signed [SUM_W-1:0]   sum;
    logic [SUM_W-DATA_W:0]     high_bits;
    word_t                     res_next;
    logic                      ovf_next;
    word_t                     res_reg;
    logic                      ovf_reg;

    // Snapshot the coefficients of this lane when the transaction is accepted
    always_ff @(posedge clk)
    begin
        if (ctrl.load_op)
        begin
            for (int a = 0; a < LANES; a++)
            begin
                coef_reg[a] <= coef[a];
            end
        end
    end

    // Multiply and floor each product by the fraction width
    always_comb
    begin
        for (int a = 0; a < LANES; a++)
        begin
            full[a] = coef_reg[a] * vec[a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            for (int a = 0; a < LANES; a++)
            begin
                prod_reg[a] <= full[a][FULL_W-1:FRAC_BITS];
            end
        end
    end

    // Sum exactly, then clip to the signed word range
    always_comb
    begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
            + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]);
        high_bits = sum[SUM_W-1:DATA_W-1];
        if ((&high_bits) || !(|high_bits))
        begin
            res_next = sum[DATA_W-1:0];
            ovf_next = 1'b0;
        end
        else if (sum[SUM_W-1])
        begin
            res_next = {1'b1, {(DATA_W-1){1'b0}}};
            ovf_next = 1'b1;
        end
        else
        begin
            res_next = {1'b0, {(DATA_W-1){1'b1}}};
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_sum)
        begin
            res_reg <= res_next;
            ovf_reg <= ovf_next;
        end
    end

    assign res = res_reg;
    assign ovf = ovf_reg;

endmodule

/* design/avt_merge.sv */
// Merge stage: combines the lane results into one output transaction.
// Depends on avt_pkg.
module avt_merge
    import avt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  merge_ctrl_t ctrl,
    input  word_t       lane_res [LANES],
    input  logic [LANES-1:0] lane_ovf,
    output logic        drain,
    output logic        out_valid,
    input  logic        out_stall,
    output word_t       out_x,
    output word_t       out_y,
    output word_t       out_z,
    output word_t       out_w,
    output logic        overflow
);

    logic  out_valid_reg;
    logic  out_valid_next;
    logic  out_load;
    logic  slot_free;
    logic  homog;
    word_t w_next;
    logic  ovf_next;
    word_t x_reg;
    word_t y_reg;
    word_t z_reg;
    word_t w_reg;
    logic  ovf_reg;

    // Invert drains without a result; transforms need a free output slot
    always_comb
    begin
        slot_free      = !out_valid_reg || !out_stall;
        out_load       = ctrl.valid && (ctrl.cmd != CMD_INVERT) && slot_free;
        drain          = ctrl.valid && ((ctrl.cmd == CMD_INVERT) || slot_free);
        out_valid_next = out_load || (out_valid_reg && out_stall);
        homog          = (ctrl.cmd == CMD_HOMOG);
        w_next         = homog ? lane_res[3] : '0;
        ovf_next       = homog ? (|lane_ovf) : (|lane_ovf[2:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the payload while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            x_reg   <= lane_res[0];
            y_reg   <= lane_res[1];
            z_reg   <= lane_res[2];
            w_reg   <= w_next;
            ovf_reg <= ovf_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_w     = w_reg;
    assign overflow  = ovf_reg;

endmodule

/* design/affine_vertex_transform_core.sv */
// Top level of the affine vertex transform: matrix store, operand select,
// four dot-product lanes and the merge stage. Depends on avt_pkg, avt_lane, avt_merge.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transaction:
//   load column, invert rigid, point, direction or homogeneous transform.
//   Output channel (out_valid / out_stall) carries one result per transform.
//   Load column updates the matrix at the accepting edge and gives no result.
//   Transforms: four lanes, one per output component, each a 32x33 multiply
//   stage followed by an add-and-clip stage; the result is then held in the
//   output register.
//   Throughput is one transform per cycle while the input is not stalled.
//   Invert rigid runs through the lanes to form the new translation, so
//   after it is accepted the input is stalled until the write-back.
//   When the receiver stalls, the output register holds and the three lane
//   stages keep filling; once they are full, in_stall rises.
//   Reset clears all pending transactions and loads the identity matrix.
//   Codes 5 to 7 are accepted and dropped.
module affine_vertex_transform_core
    import avt_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [1:0]  column_index,
    input  word_t       in_x,
    input  word_t       in_y,
    input  word_t       in_z,
    input  word_t       in_w,
    output logic        out_valid,
    input  logic        out_stall,
    output word_t       out_x,
    output word_t       out_y,
    output word_t       out_z,
    output word_t       out_w,
    output logic        overflow
);

    localparam word_t  ONE   = DATA_W'(1) << FRAC_BITS;
    localparam vword_t ONE_V = VEC_W'(1) << FRAC_BITS;

    word_t       mat_reg [MAT_N];
    word_t       mat_next [MAT_N];
    word_t       in_vec [LANES];
    vword_t      vec_reg [LANES];
    vword_t      vec_next [LANES];
    word_t       coef [LANES][LANES];
    word_t       lane_res [LANES];
    logic [LANES-1:0] lane_ovf;
    lane_ctrl_t  lane_ctrl;
    merge_ctrl_t merge_ctrl;
    cmd_t        cmd_in;
    cmd_t        cmd1_reg;
    cmd_t        cmd2_reg;
    cmd_t        cmd3_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        accept;
    logic        ld1;
    logic        ld2;
    logic        ld3;
    logic        drain;
    logic        inv_busy;

    assign cmd_in    = cmd_t'(command);
    assign in_vec[0] = in_x;
    assign in_vec[1] = in_y;
    assign in_vec[2] = in_z;
    assign in_vec[3] = in_w;

    // Advance the elastic pipeline from the merge stage backwards
    always_comb
    begin
        ld3      = v2_reg && (!v3_reg || drain);
        ld2      = v1_reg && (!v2_reg || ld3);
        inv_busy = (v1_reg && (cmd1_reg == CMD_INVERT))
                || (v2_reg && (cmd2_reg == CMD_INVERT))
                || (v3_reg && (cmd3_reg == CMD_INVERT));
        in_stall = (v1_reg && !ld2) || inv_busy;
        accept   = in_valid && !in_stall;
        ld1      = accept && (cmd_in inside {CMD_INVERT, CMD_POINT,
                                             CMD_DIRECTION, CMD_HOMOG});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            cmd1_reg <= CMD_LOAD;
            cmd2_reg <= CMD_LOAD;
            cmd3_reg <= CMD_LOAD;
        end
        else
        begin
            v1_reg <= ld1 || (v1_reg && !ld2);
            v2_reg <= ld2 || (v2_reg && !ld3);
            v3_reg <= ld3 || (v3_reg && !drain);
            if (ld1)
            begin
                cmd1_reg <= cmd_in;
            end
            if (ld2)
            begin
                cmd2_reg <= cmd1_reg;
            end
            if (ld3)
            begin
                cmd3_reg <= cmd2_reg;
            end
        end
    end

    // Select the shared vector operand: input vector, or minus old translation; w is in_w, one or zero by command
    always_comb
    begin
        for (int k = 0; k < LANES - 1; k++)
        begin
            if (cmd_in == CMD_INVERT)
            begin
                vec_next[k] = -{mat_reg[12 + k][DATA_W-1], mat_reg[12 + k]};
            end
            else
            begin
                vec_next[k] = {in_vec[k][DATA_W-1], in_vec[k]};
            end
        end
        case (cmd_in)
            CMD_HOMOG: vec_next[3] = {in_w[DATA_W-1], in_w};
            CMD_POINT: vec_next[3] = ONE_V;
            default:   vec_next[3] = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                vec_reg[k] <= vec_next[k];
            end
        end
    end

    // Select lane coefficients: a column for transforms, a row for invert
    always_comb
    begin
        for (int b = 0; b < LANES; b++)
        begin
            for (int a = 0; a < LANES; a++)
            begin
                if ((cmd_in == CMD_INVERT) && (b < LANES - 1))
                begin
                    coef[b][a] = (a < LANES - 1) ? mat_reg[4 * b + a] : '0;
                end
                else
                begin
                    coef[b][a] = mat_reg[4 * a + b];
                end
            end
        end
    end

    assign lane_ctrl.load_op   = ld1;
    assign lane_ctrl.load_prod = ld2;
    assign lane_ctrl.load_sum  = ld3;

    for (genvar b = 0; b < LANES; b++)
    begin : g_lane
        avt_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .ctrl (lane_ctrl),
            .coef (coef[b]),
            .vec  (vec_reg),
            .res  (lane_res[b]),
            .ovf  (lane_ovf[b])
        );
    end

    assign merge_ctrl.valid = v3_reg;
    assign merge_ctrl.cmd   = cmd3_reg;

    avt_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (merge_ctrl),
        .lane_res  (lane_res),
        .lane_ovf  (lane_ovf),
        .drain     (drain),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_w     (out_w),
        .overflow  (overflow)
    );

    // Update the matrix: column load, transpose on invert, translation write-back
    always_comb
    begin
        for (int i = 0; i < MAT_N; i++)
        begin
            mat_next[i] = mat_reg[i];
        end
        if (accept && (cmd_in == CMD_LOAD))
        begin
            for (int a = 0; a < LANES; a++)
            begin
                mat_next[4 * a + int'(column_index)] = in_vec[a];
            end
        end
        else if (accept && (cmd_in == CMD_INVERT))
        begin
            for (int a = 0; a < LANES - 1; a++)
            begin
                for (int b = 0; b < LANES - 1; b++)
                begin
                    mat_next[4 * a + b] = mat_reg[4 * b + a];
                end
                mat_next[4 * a + 3] = '0;
            end
            mat_next[15] = ONE;
        end
        if (drain && (cmd3_reg == CMD_INVERT))
        begin
            for (int b = 0; b < LANES - 1; b++)
            begin
                mat_next[12 + b] = lane_res[b];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAT_N; i++)
            begin
                mat_reg[i] <= ((i / 4) == (i % 4)) ? ONE : '0;
            end
        end
        else
        begin
            for (int i = 0; i < MAT_N; i++)
            begin
                mat_reg[i] <= mat_next[i];
            end
        end
    end

endmodule

/* design/avt_checker.sv */
// Port-level checks for the affine vertex transform, bound to the top level.
// Depends on avt_pkg and affine_vertex_transform_core.
module avt_checker
    import avt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [2:0] command,
    input logic       out_valid,
    input logic       out_stall,
    input word_t      out_x,
    input word_t      out_y,
    input word_t      out_z,
    input word_t      out_w,
    input logic       overflow
);

    localparam word_t SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Hold a stalled output transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_z) && $stable(out_w) && $stable(overflow))
    else $error("stalled output transaction changed");

    // A raised overflow flag comes with a clipped component
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> (out_x == SAT_MAX) || (out_x == SAT_MIN)
            || (out_y == SAT_MAX) || (out_y == SAT_MIN)
            || (out_z == SAT_MAX) || (out_z == SAT_MIN)
            || (out_w == SAT_MAX) || (out_w == SAT_MIN))
    else $error("overflow without a saturated component");

    // Invert holds the input: in_stall must rise once an invert is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (command == CMD_INVERT) |=> in_stall)
    else $error("input accepted while invert in flight");

endmodule

bind affine_vertex_transform_core avt_checker u_avt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w),
    .overflow  (overflow)
);

/* verif/tb_affine_vertex_transform_core.sv */
// Self-checking testbench for affine_vertex_transform_core: directed table, then random traffic.
// Depends on avt_pkg and the core; uses typed-row values, else its own fixed-point matrix model.
module tb_affine_vertex_transform_core;
    import avt_pkg::*;

    localparam int      FRAC_BITS    = DEF_FRAC_BITS;
    localparam int      RANDOM_ITEMS = 1100;
    localparam int      LONG_HOLD    = 300;
    localparam int      DRAIN_CYCLES = 8;
    localparam word_t   WMAX         = 32'sh7FFF_FFFF;
    localparam word_t   WMIN         = 32'sh8000_0000;
    localparam word_t   ONE          = 32'sh0001_0000;
    localparam word_t   ZERO         = 32'sh0000_0000;
    // codes the block accepts and drops
    localparam logic [2:0] CMD_SPARE5 = 3'd5;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
        word_t w;
        logic  ovf;
    } vec_result_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [1:0]  col;
        word_t       x;
        word_t       y;
        word_t       z;
        word_t       w;
        bit          typed;
        vec_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  command = CMD_LOAD;
    logic [1:0]  column_index = 2'd0;
    word_t       in_x = '0;
    word_t       in_y = '0;
    word_t       in_z = '0;
    word_t       in_w = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    word_t       out_x;
    word_t       out_y;
    word_t       out_z;
    word_t       out_w;
    logic        overflow;

    longint      model_matrix [16];
    vec_result_t expected_vectors [$];
    stim_row_t   directed [$];
    int          mismatch_count = 0;
    bit          calm = 1'b0;
    bit          hold_request = 1'b0;

    affine_vertex_transform_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .column_index (column_index),
        .in_x         (in_x),
        .in_y         (in_y),
        .in_z         (in_z),
        .in_w         (in_w),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .out_w        (out_w),
        .overflow     (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Product of two fixed-point values, floored by the fraction width
    function automatic longint floor_product(longint a, longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic longint clip_word(longint v, inout bit ovf);
        if (v > longint'(WMAX))
        begin
            ovf = 1'b1;
            return longint'(WMAX);
        end
        if (v < longint'(WMIN))
        begin
            ovf = 1'b1;
            return longint'(WMIN);
        end
        return v;
    endfunction

    // Advance the matrix model by one transaction; return 1 when a vector comes out
    function automatic bit apply_command(stim_row_t s, output vec_result_t r);
        longint prior [16];
        longint vin [4];
        longint res [4];
        longint acc;
        bit     ovf;
        bit     dropped;
        int     n;
        ovf = 1'b0;
        dropped = 1'b0;
        r = '0;
        vin[0] = longint'(s.x);
        vin[1] = longint'(s.y);
        vin[2] = longint'(s.z);
        vin[3] = longint'(s.w);
        for (int b = 0; b < 4; b++)
            res[b] = 0;
        case (s.cmd)
            CMD_LOAD:
            begin
                for (int a = 0; a < 4; a++)
                    model_matrix[4 * a + s.col] = vin[a];
                return 1'b0;
            end
            CMD_INVERT:
            begin
                for (int a = 0; a < 16; a++)
                    prior[a] = model_matrix[a];
                for (int a = 0; a < 3; a++)
                    for (int b = 0; b < 3; b++)
                        model_matrix[4 * a + b] = prior[4 * b + a];
                for (int a = 0; a < 3; a++)
                    model_matrix[4 * a + 3] = 0;
                model_matrix[15] = longint'(ONE);
                // new translation is minus transposed rotation times old translation
                for (int b = 0; b < 3; b++)
                begin
                    acc = 0;
                    for (int k = 0; k < 3; k++)
                        acc += floor_product(prior[4 * b + k], -prior[12 + k]);
                    model_matrix[12 + b] = clip_word(acc, dropped);
                end
                return 1'b0;
            end
            CMD_POINT, CMD_DIRECTION, CMD_HOMOG:
            begin
                n = (s.cmd == CMD_HOMOG) ? 4 : 3;
                for (int b = 0; b < n; b++)
                begin
                    acc = 0;
                    for (int a = 0; a < n; a++)
                        acc += floor_product(model_matrix[4 * a + b], vin[a]);
                    if (s.cmd == CMD_POINT)
                        acc += model_matrix[12 + b];
                    res[b] = clip_word(acc, ovf);
                end
                r.x = word_t'(res[0]);
                r.y = word_t'(res[1]);
                r.z = word_t'(res[2]);
                r.w = word_t'(res[3]);
                r.ovf = ovf;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic stim_row_t row(logic [2:0] c, logic [1:0] col,
                                      word_t x, word_t y, word_t z, word_t w, bit typed,
                                      word_t ex, word_t ey, word_t ez, word_t ew, logic ov);
        stim_row_t s;
        s.cmd = c;
        s.col = col;
        s.x = x;
        s.y = y;
        s.z = z;
        s.w = w;
        s.typed = typed;
        s.want.x = ex;
        s.want.y = ey;
        s.want.z = ez;
        s.want.w = ew;
        s.want.ovf = ov;
        return s;
    endfunction

    // Mostly small values within +-4.0, with extremes and full-range words mixed in
    function automatic word_t rand_word();
        case ($urandom_range(0, 9))
            0: return WMAX;
            1: return WMIN;
            2: return word_t'($urandom);
            default: return word_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    // Idle length in cycles: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %h want %h at %0t", what, got[31:0], want[31:0], $realtime);
        mismatch_count++;
    endtask

    // Offer one transaction, hold it until accepted, then log what it should produce
    task automatic offer(stim_row_t s);
        vec_result_t r;
        in_valid     <= 1'b1;
        command      <= s.cmd;
        column_index <= s.col;
        in_x         <= s.x;
        in_y         <= s.y;
        in_z         <= s.z;
        in_w         <= s.w;
        do
            @(posedge clk);
        while (in_stall);
        if (apply_command(s, r))
            expected_vectors.push_back(s.typed ? s.want : r);
    endtask

    task automatic idle_sender();
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stimulus: reset, directed table, random traffic, drain
    initial
    begin : stimulus
        stim_row_t s;
        int        random_sent;
        int        offered;
        int        pick;
        random_sent = 0;
        offered = 0;
        for (int i = 0; i < 16; i++)
            model_matrix[i] = (i % 5 == 0) ? longint'(ONE) : 0;

        // identity transforms after reset
        directed.push_back(row(CMD_POINT, 2'd0, ONE, -32'sh0002_8000, 32'sh0003_4000, 32'sh1234,
                               1, ONE, -32'sh0002_8000, 32'sh0003_4000, ZERO, 1'b0));
        directed.push_back(row(CMD_HOMOG, 2'd0, WMIN, WMAX, WMIN, WMAX,
                               1, WMIN, WMAX, WMIN, WMAX, 1'b0));
        directed.push_back(row(CMD_DIRECTION, 2'd3, WMAX, WMIN, ZERO, -32'sd1,
                               1, WMAX, WMIN, ZERO, ZERO, 1'b0));
        directed.push_back(row(CMD_SPARE5, 2'd1, WMAX, ONE, ONE, ONE, 0, 0, 0, 0, 0, 1'b0));
        directed.push_back(row(CMD_SPARE6, 2'd2, WMIN, ONE, ONE, ONE, 0, 0, 0, 0, 0, 1'b0));
        directed.push_back(row(CMD_SPARE7, 2'd3, ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, 1'b0));
        // saturation in both directions
        directed.push_back(row(CMD_LOAD, 2'd0, WMAX, WMAX, WMAX, WMAX, 0, 0, 0, 0, 0, 1'b0));
        directed.push_back(row(CMD_DIRECTION, 2'd0, WMAX, WMAX, WMAX, ZERO,
                               1, WMAX, WMAX, WMAX, ZERO, 1'b1));
        directed.push_back(row(CMD_DIRECTION, 2'd0, WMIN, WMIN, WMIN, ZERO,
                               1, WMIN, WMIN, WMIN, ZERO, 1'b1));
        directed.push_back(row(CMD_HOMOG, 2'd0, ONE, ZERO, ZERO, ZERO, 0, 0, 0, 0, 0, 1'b0));
        // translation, then point with it
        directed.push_back(row(CMD_LOAD, 2'd0, ONE, ZERO, ZERO, 32'sh0005_0000,
                               0, 0, 0, 0, 0, 1'b0));
        directed.push_back(row(CMD_LOAD, 2'd1, ZERO, ONE, ZERO, -32'sh0007_0000,
                               0, 0, 0, 0, 0, 1'b0));
        directed.push_back(row(CMD_LOAD, 2'd2, ZERO, ZERO, ONE, WMAX, 0, 0, 0, 0, 0, 1'b0));
        directed.push_back(row(CMD_POINT, 2'd0, ZERO, ZERO, ZERO, ZERO,
                               1, 32'sh0005_0000, -32'sh0007_0000, WMAX, ZERO, 1'b0));
        directed.push_back(row(CMD_POINT, 2'd0, ONE, ONE, ONE, ZERO,
                               1, 32'sh0006_0000, -32'sh0006_0000, WMAX, ZERO, 1'b1));
        // rigid inverse negates the translation
        directed.push_back(row(CMD_INVERT, 2'd0, ZERO, ZERO, ZERO, ZERO, 0, 0, 0, 0, 0, 1'b0));
        directed.push_back(row(CMD_POINT, 2'd0, ZERO, ZERO, ZERO, ZERO,
                               1, -32'sh0005_0000, 32'sh0007_0000, -WMAX, ZERO, 1'b0));
        // minus the most negative word clips silently to the maximum
        directed.push_back(row(CMD_LOAD, 2'd0, ONE, ZERO, ZERO, WMIN, 0, 0, 0, 0, 0, 1'b0));
        directed.push_back(row(CMD_INVERT, 2'd0, ZERO, ZERO, ZERO, ZERO, 0, 0, 0, 0, 0, 1'b0));
        directed.push_back(row(CMD_POINT, 2'd0, ZERO, ZERO, ZERO, ZERO,
                               1, WMAX, -32'sh0007_0000, WMAX, ZERO, 1'b0));
        // rotation-like content, negative products that floor
        directed.push_back(row(CMD_LOAD, 2'd3, 32'sh0000_8000, -ONE, 32'sh0002_0000, WMIN,
                               0, 0, 0, 0, 0, 1'b0));
        directed.push_back(row(CMD_LOAD, 2'd1, 32'sh0000_B505, 32'sh0000_B505, ZERO,
                               32'sh0003_0000, 0, 0, 0, 0, 0, 1'b0));
        directed.push_back(row(CMD_HOMOG, 2'd0, -32'sd1, 32'sd1, WMAX, WMIN,
                               0, 0, 0, 0, 0, 1'b0));
        directed.push_back(row(CMD_INVERT, 2'd0, ZERO, ZERO, ZERO, ZERO, 0, 0, 0, 0, 0, 1'b0));
        directed.push_back(row(CMD_POINT, 2'd0, -32'sd3, 32'sd7, -32'sd1, ZERO,
                               0, 0, 0, 0, 0, 1'b0));
        directed.push_back(row(CMD_DIRECTION, 2'd0, ONE, -ONE, ONE, ZERO, 0, 0, 0, 0, 0, 1'b0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            offer(directed[i]);
            idle_sender();
        end

        // random traffic; dropped codes do not count
        while (random_sent < RANDOM_ITEMS)
        begin
            s = '0;
            s.col = 2'($urandom_range(0, 3));
            s.x = rand_word();
            s.y = rand_word();
            s.z = rand_word();
            s.w = rand_word();
            pick = $urandom_range(0, 99);
            if (pick < 15)
                s.cmd = CMD_LOAD;
            else if (pick < 20)
                s.cmd = CMD_INVERT;
            else if (pick < 24)
                s.cmd = 3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
            else
                s.cmd = 3'($urandom_range(CMD_POINT, CMD_HOMOG));
            offer(s);
            offered++;
            if (s.cmd <= CMD_HOMOG)
                random_sent++;
            if (offered % 64 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (random_sent == 400)
                hold_request = 1'b1;
            idle_sender();
        end
        in_valid <= 1'b0;

        // drain outstanding vectors, then let the pipeline settle
        while (expected_vectors.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    initial
    begin : receiver
        int  stall_left;
        int  gap;
        bit  hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                gap = pick_gap();
                out_stall <= (gap > 0);
                stall_left = (gap > 0) ? gap - 1 : 0;
            end
        end
    end

    // Compare each accepted vector with the oldest expectation
    always @(posedge clk)
    begin : result_check
        vec_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_vectors.size() == 0)
                flag_mismatch("unexpected vector, out_x", longint'(out_x), 0);
            else
            begin
                want = expected_vectors.pop_front();
                if (out_x !== want.x)
                    flag_mismatch("out_x", longint'(out_x), longint'(want.x));
                if (out_y !== want.y)
                    flag_mismatch("out_y", longint'(out_y), longint'(want.y));
                if (out_z !== want.z)
                    flag_mismatch("out_z", longint'(out_z), longint'(want.z));
                if (out_w !== want.w)
                    flag_mismatch("out_w", longint'(out_w), longint'(want.w));
                if (overflow !== want.ovf)
                    flag_mismatch("overflow", longint'(overflow), longint'(want.ovf));
            end
        end
    end

    // Stop a hung run
    initial
    begin : watchdog
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
design/avt_pkg.sv
design/avt_lane.sv
design/avt_merge.sv
design/affine_vertex_transform_core.sv
design/avt_checker.sv
verif/tb_affine_vertex_transform_core.sv
